// ===== rtl/core/rfol_pkg.sv =====
package rfol_pkg;

	localparam int WORD_W    = 32;
	localparam int FIELD_W   = 5;
	localparam int OCC_W     = 4;
	localparam int OFF_OUT_W = 12;
	localparam int STATUS_W  = 2;
	// Running offset width; enough for sixteen fully populated words.
	localparam int RUN_W     = 12;
	localparam int EXT_BIT   = 31;
	localparam int WALK_BITS = 31;
	localparam int BIT_W     = 5;
	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 16;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FOUND     = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic start;
		logic load;
		logic step;
	} walk_ctl_t;

	typedef struct packed {
		logic hit;
		logic last_bit;
		logic ext;
	} walk_stat_t;

	// Alignment minus one of each radiotap field; zero for bits without an entry.
	function automatic logic [2:0] fld_mask(input logic [BIT_W-1:0] b);
		logic [2:0] m;
		unique case (b) inside
			5'd0, 5'd22: m = 3'd7;
			5'd20: m = 3'd3;
			5'd3, 5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15, 5'd21: m = 3'd1;
			default: m = 3'd0;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] fld_size(input logic [BIT_W-1:0] b);
		logic [3:0] s;
		unique case (b) inside
			5'd0, 5'd20: s = 4'd8;
			5'd3: s = 4'd4;
			5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15: s = 4'd2;
			5'd1, 5'd2, 5'd5, 5'd6, 5'd10, 5'd11, 5'd12, 5'd13, 5'd16, 5'd17: s = 4'd1;
			5'd19: s = 4'd3;
			5'd21, 5'd22: s = 4'd12;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/rfol_walker.sv =====
module rfol_walker
	import rfol_pkg::*;
#(
	parameter int MAX_WORDS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  walk_ctl_t            ctl,
	input  logic [WORD_W-1:0]    word,
	input  logic [RUN_W-1:0]     start_off,
	input  logic [FIELD_W-1:0]   target_field,
	input  logic [OCC_W-1:0]     wanted_occurrence,
	output walk_stat_t           stat,
	output logic [RUN_W-1:0]     offset
);

	localparam int SEEN_W = $clog2(MAX_WORDS + 1);
	localparam int CMP_W  = (SEEN_W + 1 > OCC_W) ? SEEN_W + 1 : OCC_W;

	logic [WALK_BITS-1:0] sh_q;
	logic                 ext_q;
	logic [BIT_W-1:0]     bit_q;
	logic [RUN_W-1:0]     off_q;
	logic [SEEN_W-1:0]    seen_q;
	logic [FIELD_W-1:0]   wf_q;
	logic [OCC_W-1:0]     wo_q;

	logic [RUN_W-1:0] mask;
	logic [RUN_W-1:0] padded;
	logic [SEEN_W:0]  seen_nx;
	logic             match;
	logic             hit;

	assign mask    = RUN_W'(fld_mask(bit_q));
	assign padded  = (off_q + mask) & ~mask;
	assign seen_nx = {1'b0, seen_q} + 1'b1;
	assign match   = sh_q[0] && (bit_q == wf_q);
	assign hit     = ctl.step && match && (CMP_W'(seen_nx) == CMP_W'(wo_q));

	assign stat.hit      = hit;
	assign stat.last_bit = (bit_q == BIT_W'(WALK_BITS - 1));
	assign stat.ext      = ext_q;
	assign offset        = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			seen_q <= '0;
		end else if (ctl.start) begin
			seen_q <= '0;
		end else if (ctl.load) begin
			bit_q <= '0;
		end else if (ctl.step) begin
			bit_q <= bit_q + 1'b1;
			if (match) begin
				seen_q <= seen_nx[SEEN_W-1:0];
			end
		end
	end

	// One presence bit is examined per cycle, lowest bit first.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			off_q <= start_off;
			wf_q  <= target_field;
			wo_q  <= wanted_occurrence;
		end else if (ctl.load) begin
			sh_q  <= word[WALK_BITS-1:0];
			ext_q <= word[EXT_BIT];
		end else if (ctl.step) begin
			sh_q <= sh_q >> 1;
			if (sh_q[0]) begin
				if (hit) begin
					off_q <= padded;
				end else begin
					off_q <= padded + RUN_W'(fld_size(bit_q));
				end
			end
		end
	end

endmodule

// ===== rtl/core/radiotap_field_offset_locator_top.sv =====
// Radiotap field offset locator.
// Input stream: one transfer per 32-bit presence word of a radiotap header;
// tlast marks the final word, and the wanted field number and occurrence are
// taken from that final transfer. Output stream: one transfer per header with
// the status (found, not found, too many words) and the byte offset of the
// wanted field occurrence, padded to the field's alignment.
// Non-final words are taken one per cycle. After the final word the walker
// examines one presence bit per cycle: each stored word walked passes a load
// state and then steps through its 31 presence bits, and the done state comes
// before the result is offered. The walk stops at the hit or at the end of the chain.
// An overflowed header skips the walk and goes straight to the done state.
// While a header is being walked, tready is low. A finished result sits in
// the output register; further words are taken meanwhile, but the next walk
// result waits, with tready low, until the receiver has taken the previous one.
// Reset clears the word count, the overflow mark, the sequencer and the
// output valid; the word store itself needs no clearing.
module radiotap_field_offset_locator_top
	import rfol_pkg::*;
#(
	parameter int MAX_WORDS   = 8,
	parameter int OFFSET_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// presence_word[31:0], wanted_field[36:32], wanted_occurrence[40:37], zero fill
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// status[1:0], field_offset[13:2], zero fill
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int CNT_W = $clog2(MAX_WORDS + 1);
	localparam int IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned OFF_MAX_I = (1 << OFFSET_BITS) - 1;
	localparam logic [16:0] OFF_MAX = 17'(OFF_MAX_I);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_WALK = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [WORD_W-1:0]  store_q [MAX_WORDS];
	logic [CNT_W-1:0]   count_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   w_q;
	status_t            res_q;
	logic               m_valid_q;
	status_t            m_status_q;
	logic [OFF_OUT_W-1:0] m_off_q;

	walk_ctl_t          wctl;
	walk_stat_t         wstat;
	logic [RUN_W-1:0]   walk_off;
	logic [RUN_W-1:0]   start_off;
	logic               s_acc;
	logic               full;
	logic               out_free;
	logic [16:0]        off_ext;
	logic [16:0]        off_sat;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(MAX_WORDS));
	assign out_free = !m_valid_q || m_tready;
	// Header length plus one presence word: 4 * (count + 1) + 4.
	assign start_off = (RUN_W'(count_q) << 2) + RUN_W'(8);

	assign wctl.start = s_acc && s_tlast && !ovf_q && !full;
	assign wctl.load  = (state_q == ST_LOAD);
	assign wctl.step  = (state_q == ST_WALK);

	assign off_ext = 17'(walk_off);
	assign off_sat = (off_ext > OFF_MAX) ? OFF_MAX : off_ext;

	rfol_walker #(
		.MAX_WORDS(MAX_WORDS)
	) u_walker (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (wctl),
		.word             (store_q[w_q[IDX_W-1:0]]),
		.start_off        (start_off),
		.target_field     (s_tdata[36:32]),
		.wanted_occurrence(s_tdata[40:37]),
		.stat             (wstat),
		.offset           (walk_off)
	);

	always_ff @(posedge clk) begin
		if (s_acc && !full) begin
			store_q[count_q[IDX_W-1:0]] <= s_tdata[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			w_q       <= '0;
			res_q     <= STATUS_NOT_FOUND;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (s_tlast) begin
							w_q <= '0;
							if (ovf_q || full) begin
								res_q   <= STATUS_OVERFLOW;
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_LOAD;
							end
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (wstat.hit) begin
						res_q   <= STATUS_FOUND;
						state_q <= ST_DONE;
					end else if (wstat.last_bit) begin
						// The chain ends at a word without the extension bit
						// or at the last stored word.
						if (!wstat.ext || (w_q + 1'b1 == count_q)) begin
							res_q   <= STATUS_NOT_FOUND;
							state_q <= ST_DONE;
						end else begin
							w_q     <= w_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						count_q   <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_status_q <= res_q;
			m_off_q    <= (res_q == STATUS_FOUND) ? off_sat[OFF_OUT_W-1:0] : '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_off_q, m_status_q};

endmodule

// ===== rtl/core/rfol_checker.sv =====
module rfol_checker
	import rfol_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                s_tlast,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// A stalled result transfer keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only the three defined status codes appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == STATUS_FOUND) || (m_tdata[1:0] == STATUS_NOT_FOUND)
			|| (m_tdata[1:0] == STATUS_OVERFLOW))
		else $error("undefined status code");

	// The offset is zero unless the field was found.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != STATUS_FOUND) |-> m_tdata[13:2] == '0)
		else $error("offset given without a hit");

	// A final word starts the walk or, on overflow, the done state; both hold off further input.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken during a walk");

	// A word that is not the last of its header gives no result.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid)
		else $error("result without a final word");

endmodule

bind radiotap_field_offset_locator_top rfol_checker u_rfol_checker (.*);
